### sv/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg
// Types and constants shared by the buddy allocator controller and datapath.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int OFFSET_W = 30;
  localparam int HDR_W    = 8;
  localparam int LOG_W    = 5;
  localparam int STATUS_W = 2;
  localparam int ORDER_W  = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_SIZE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES     = 2'd2;

  localparam logic [LOG_W-1:0] RST_BLOCK_SIZE_LOG2  = 5'd7;
  localparam logic [LOG_W-1:0] RST_MEMORY_SIZE_LOG2 = 5'd17;
  localparam logic [HDR_W-1:0] RST_HEADER_BYTES     = 8'd16;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  typedef enum logic [1:0] {
    RES_ALLOC   = 2'd0,
    RES_FREE    = 2'd1,
    RES_NOFIT   = 2'd2,
    RES_BADFREE = 2'd3
  } res_t;

  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic load;
    logic ord_init;
    logic ord_step;
    logic srch_init;
    logic srch_lvl;
    logic srch_next;
    logic take;
    logic split_step;
    logic grant;
    logic release_blk;
    logic sib;
    logic merge;
    logic settle;
    logic out_load;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic clr_last;
    logic is_free;
    logic too_large;
    logic bad_free;
    logic ord_done;
    logic hit;
    logic lvl_end;
    logic k_top;
    logic k_ord;
    logic in_use;
    logic can_merge;
    logic out_busy;
  } sts_t;

endpackage

### sv/bma_ram.sv
// ----------------------------------------------------------------------------
// bma_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bma_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bma_ctrl.sv
// ----------------------------------------------------------------------------
// bma_ctrl
// Sequencer for the buddy allocator: clear, search, split, grant, free, merge.
// ----------------------------------------------------------------------------
module bma_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  bma_pkg::sts_t sts,
  output bma_pkg::cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CLR   = 14'b00000000000010,
    S_DEC   = 14'b00000000000100,
    S_ORD   = 14'b00000000001000,
    S_SRD   = 14'b00000000010000,
    S_SCK   = 14'b00000000100000,
    S_TAKE  = 14'b00000001000000,
    S_SPLIT = 14'b00000010000000,
    S_GRANT = 14'b00000100000000,
    S_URD   = 14'b00001000000000,
    S_UCK   = 14'b00010000000000,
    S_MRD   = 14'b00100000000000,
    S_MCK   = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t        state, state_next;
  bma_pkg::res_t res, res_next;

  assign s_tready = (state == S_IDLE) && !sts.cfg_wr;

  always_comb begin
    cmd        = '0;
    state_next = state;
    res_next   = res;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_DEC: begin
        if (sts.is_free) begin
          if (sts.bad_free) begin
            res_next   = bma_pkg::RES_BADFREE;
            state_next = S_FIN;
          end else begin
            state_next = S_URD;
          end
        end else if (sts.too_large) begin
          res_next   = bma_pkg::RES_NOFIT;
          state_next = S_FIN;
        end else begin
          cmd.ord_init = 1'b1;
          state_next   = S_ORD;
        end
      end
      S_ORD: begin
        if (sts.ord_done) begin
          cmd.srch_init = 1'b1;
          state_next    = S_SRD;
        end else begin
          cmd.ord_step = 1'b1;
        end
      end
      S_SRD: state_next = S_SCK;
      S_SCK: begin
        if (sts.hit) begin
          state_next = S_TAKE;
        end else if (sts.lvl_end) begin
          if (sts.k_top) begin
            res_next   = bma_pkg::RES_NOFIT;
            state_next = S_FIN;
          end else begin
            cmd.srch_lvl = 1'b1;
            state_next   = S_SRD;
          end
        end else begin
          cmd.srch_next = 1'b1;
          state_next    = S_SRD;
        end
      end
      S_TAKE: begin
        cmd.take   = 1'b1;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if (sts.k_ord) state_next = S_GRANT;
        else cmd.split_step = 1'b1;
      end
      S_GRANT: begin
        cmd.grant  = 1'b1;
        res_next   = bma_pkg::RES_ALLOC;
        state_next = S_FIN;
      end
      S_URD: state_next = S_UCK;
      S_UCK: begin
        if (!sts.in_use) begin
          res_next   = bma_pkg::RES_BADFREE;
          state_next = S_FIN;
        end else begin
          cmd.release_blk = 1'b1;
          state_next      = S_MRD;
        end
      end
      S_MRD: begin
        cmd.sib    = 1'b1;
        state_next = S_MCK;
      end
      S_MCK: begin
        if (sts.can_merge) begin
          cmd.merge  = 1'b1;
          state_next = S_MRD;
        end else begin
          cmd.settle = 1'b1;
          res_next   = bma_pkg::RES_FREE;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.res = res;
    if (sts.cfg_wr) begin
      cmd          = '0;
      cmd.clr_init = 1'b1;
      state_next   = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      res   <= bma_pkg::RES_ALLOC;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

endmodule

### sv/bma_dp.sv
// ----------------------------------------------------------------------------
// bma_dp
// Allocator datapath: configuration, tree and block memories, walk registers
// and the result register.
// ----------------------------------------------------------------------------
module bma_dp #(
  parameter int MAX_BLOCKS = 1024,
  parameter int MAX_ORDER  = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bma_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bma_pkg::HDR_W-1:0]           cfg_data,
  input  logic [63:0]                         s_tdata,
  input  logic                                s_tuser,
  output logic [39:0]                         m_tdata,
  output logic [bma_pkg::STATUS_W-1:0]        m_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  bma_pkg::cmd_t                       cmd,
  output bma_pkg::sts_t                       sts
);

  localparam int DEPTH   = 2 * MAX_BLOCKS;
  localparam int NW      = $clog2(DEPTH);
  localparam int UW      = $clog2(MAX_BLOCKS);
  localparam int LOG_BLK = $clog2(MAX_BLOCKS + 1) - 1;
  localparam int LIM     = (MAX_ORDER < LOG_BLK) ? MAX_ORDER : LOG_BLK;
  localparam int KW      = $clog2(LIM + 1);
  localparam int OW      = bma_pkg::OFFSET_W;

  logic [bma_pkg::LOG_W-1:0] blk, mem_log;
  logic [bma_pkg::HDR_W-1:0] hdr;
  logic                      act;
  logic [OW-1:0]             req, fo;
  logic [KW-1:0]             ord, k;
  logic [NW-1:0]             node, cnt;

  logic [bma_pkg::LOG_W-1:0] diff;
  logic [KW-1:0]             top, kf, gord;
  logic [5:0]                e_top, e_ord;
  logic [OW:0]               need;
  logic [OW-1:0]             start, bmask, sh, pay;
  logic [NW-1:0]             nsh, fnode_w, fnode_r, uaddr_unused;
  logic [UW-1:0]             unit_a, unit_f, umask, uwaddr;
  logic [UW:0]               umask_w;
  logic                      fwe, fwdata, uwe, trd;
  logic [KW:0]               uwdata, urdata;

  assign sts.cfg_wr = cfg_we && (cfg_index == bma_pkg::REG_BLOCK_SIZE_LOG2 ||
                                 cfg_index == bma_pkg::REG_MEMORY_SIZE_LOG2 ||
                                 cfg_index == bma_pkg::REG_HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      blk     <= bma_pkg::RST_BLOCK_SIZE_LOG2;
      mem_log <= bma_pkg::RST_MEMORY_SIZE_LOG2;
      hdr     <= bma_pkg::RST_HEADER_BYTES;
    end else if (cfg_we) begin
      case (cfg_index)
        bma_pkg::REG_BLOCK_SIZE_LOG2:  blk     <= cfg_data[bma_pkg::LOG_W-1:0];
        bma_pkg::REG_MEMORY_SIZE_LOG2: mem_log <= cfg_data[bma_pkg::LOG_W-1:0];
        bma_pkg::REG_HEADER_BYTES:     hdr     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    diff = mem_log - blk;
    if (mem_log <= blk) top = '0;
    else if (int'(diff) > LIM) top = KW'(LIM);
    else top = KW'(diff);
  end

  assign e_top = {1'b0, blk} + 6'(top);
  assign e_ord = {1'b0, blk} + 6'(ord);
  assign need  = {1'b0, req} + (OW+1)'(hdr);
  assign start = fo - OW'(hdr);
  assign bmask = (blk >= 5'd30) ? '1 : ((OW'(1) << blk) - OW'(1));
  assign sh    = start >> blk;
  assign unit_f = sh[UW-1:0];

  assign sts.is_free   = act;
  assign sts.too_large = (e_top < 6'd31) && (need > ((OW+1)'(1) << e_top));
  assign sts.bad_free  = (fo < OW'(hdr)) || ((start & bmask) != '0) ||
                         ((e_top < 6'd30) && (start >= (OW'(1) << e_top)));
  assign sts.ord_done  = (ord == top) || (e_ord >= 6'd31) ||
                         (((OW+1)'(1) << e_ord) >= need);
  assign sts.lvl_end   = (({1'b0, node} + (NW+1)'(1)) == ((NW+1)'(2) << (top - k)));
  assign sts.k_top     = (k == top);
  assign sts.k_ord     = (k == ord);
  assign sts.hit       = trd;
  assign sts.in_use    = urdata[KW];
  assign sts.can_merge = (k < top) && trd;
  assign sts.clr_last  = (cnt == NW'(DEPTH - 1));
  assign sts.out_busy  = m_tvalid && !m_tready;

  assign nsh     = node << k;
  assign umask_w = ((UW+1)'(1) << top) - (UW+1)'(1);
  assign umask   = umask_w[UW-1:0];
  assign unit_a  = nsh[UW-1:0] & umask;
  assign gord    = urdata[KW-1:0];
  assign kf      = (gord < top) ? gord : top;
  assign pay     = (OW'(unit_a) << blk) + OW'(hdr);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr_init) begin
      cnt <= '0;
    end else if (cmd.clr_step) begin
      cnt <= cnt + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= s_tuser;
      req <= s_tdata[OW-1:0];
      fo  <= s_tdata[2*OW-1:OW];
    end
    if (cmd.ord_init) begin
      ord <= '0;
    end else if (cmd.ord_step) begin
      ord <= ord + KW'(1);
    end else if (cmd.release_blk) begin
      ord <= kf;
    end
    if (cmd.srch_init) begin
      k    <= ord;
      node <= NW'(1) << (top - ord);
    end else if (cmd.srch_lvl) begin
      k    <= k + KW'(1);
      node <= NW'(1) << (top - k - KW'(1));
    end else if (cmd.srch_next) begin
      node <= node + NW'(1);
    end else if (cmd.split_step) begin
      k    <= k - KW'(1);
      node <= node << 1;
    end else if (cmd.release_blk) begin
      k    <= kf;
      node <= (NW'(1) << (top - kf)) + NW'(unit_f >> kf);
    end else if (cmd.merge) begin
      k    <= k + KW'(1);
      node <= node >> 1;
    end
  end

  always_comb begin
    fwe    = 1'b0;
    fnode_w = node;
    fwdata = 1'b0;
    if (cmd.clr_step) begin
      fwe     = 1'b1;
      fnode_w = cnt;
      fwdata  = (cnt == NW'(1));
    end else if (cmd.take) begin
      fwe = 1'b1;
    end else if (cmd.split_step) begin
      fwe     = 1'b1;
      fnode_w = (node << 1) | NW'(1);
      fwdata  = 1'b1;
    end else if (cmd.merge) begin
      fwe     = 1'b1;
      fnode_w = node ^ NW'(1);
    end else if (cmd.settle) begin
      fwe    = 1'b1;
      fwdata = 1'b1;
    end
  end

  assign fnode_r = cmd.sib ? (node ^ NW'(1)) : node;

  always_comb begin
    uwe          = 1'b0;
    uwaddr       = unit_f;
    uwdata       = {1'b0, gord};
    uaddr_unused = cnt;
    if (cmd.clr_step) begin
      uwe    = (cnt < NW'(MAX_BLOCKS));
      uwaddr = uaddr_unused[UW-1:0];
      uwdata = '0;
    end else if (cmd.grant) begin
      uwe    = 1'b1;
      uwaddr = unit_a;
      uwdata = {1'b1, ord};
    end else if (cmd.release_blk) begin
      uwe = 1'b1;
    end
  end

  bma_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_tree (
    .clk   (clk),
    .we    (fwe),
    .waddr (fnode_w),
    .wdata (fwdata),
    .raddr (fnode_r),
    .rdata (trd)
  );

  bma_ram #(.WIDTH(KW + 1), .DEPTH(MAX_BLOCKS)) u_blocks (
    .clk   (clk),
    .we    (uwe),
    .waddr (uwaddr),
    .wdata (uwdata),
    .raddr (unit_f),
    .rdata (urdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res)
        bma_pkg::RES_ALLOC: begin
          m_tuser <= bma_pkg::ST_OK;
          m_tdata <= {5'd0, bma_pkg::ORDER_W'(ord), pay};
        end
        bma_pkg::RES_FREE: begin
          m_tuser <= bma_pkg::ST_OK;
          m_tdata <= {5'd0, bma_pkg::ORDER_W'(ord), fo};
        end
        bma_pkg::RES_NOFIT: begin
          m_tuser <= bma_pkg::ST_NOFIT;
          m_tdata <= '0;
        end
        default: begin
          m_tuser <= bma_pkg::ST_BADFREE;
          m_tdata <= '0;
        end
      endcase
    end
  end

endmodule

### sv/buddy_memory_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_memory_allocator_core
// Binary buddy allocator: grants power-of-two blocks and merges freed buddies.
// ----------------------------------------------------------------------------
// One item at a time. After reset and after every register write a clearing
// pass over the tree and block memories runs with s_tready low. An allocate
// steps up the orders, then makes a linear scan of the free tree (one node per
// read of the tree RAM), then splits orders down; a free checks the block and
// merges freed buddies level by level. The result sits in an output register;
// the next beat is taken once that register is loaded.
module buddy_memory_allocator_core #(
  parameter int MAX_BLOCKS = 1024,
  parameter int MAX_ORDER  = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bma_pkg::HDR_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,  // request_length, free_offset
  input  logic                          s_tuser,  // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata,  // payload_offset, block_order
  output logic [bma_pkg::STATUS_W-1:0]  m_tuser   // status
);

  bma_pkg::cmd_t cmd;
  bma_pkg::sts_t sts;

  bma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bma_dp #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_ORDER(MAX_ORDER)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### sv/bma_checker.sv
// ----------------------------------------------------------------------------
// bma_checker
// Port-level checks on the buddy allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bma_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_we,
  input logic [bma_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [39:0]                   m_tdata,
  input logic [bma_pkg::STATUS_W-1:0]  m_tuser
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("beat taken during clearing pass after reset");

  a_clear_after_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index == bma_pkg::REG_BLOCK_SIZE_LOG2 ||
                cfg_index == bma_pkg::REG_MEMORY_SIZE_LOG2 ||
                cfg_index == bma_pkg::REG_HEADER_BYTES)) |=> !s_tready)
    else $error("beat taken during clearing pass after register write");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result beat changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != bma_pkg::ST_OK) |-> (m_tdata == '0))
    else $error("error result carries data");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == bma_pkg::ST_OK || m_tuser == bma_pkg::ST_NOFIT ||
                  m_tuser == bma_pkg::ST_BADFREE))
    else $error("result status out of range");

endmodule

bind buddy_memory_allocator_core bma_checker u_bma_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser)
);
